// ===== hw/rtl/scfr_pkg.sv =====
// Package with the types, constants and codes of the serial command frame receiver.
package scfr_pkg;

  // Frame store depth in bytes; bytes past this depth are counted but not stored.
  localparam int BUFFER_DEPTH = 16;
  localparam int BUF_AW       = $clog2(BUFFER_DEPTH);

  // Header, trailer and field codes.
  localparam logic [7:0] HDR_CMD_0   = 8'hEE;
  localparam logic [7:0] HDR_CMD_1   = 8'h51;
  localparam logic [7:0] HDR_UPD_0   = 8'h48;
  localparam logic [7:0] HDR_UPD_1   = 8'h05;
  localparam logic [7:0] UPD_TRAILER = 8'h58;
  localparam logic [7:0] UPD_FILL    = 8'h05;
  localparam logic [7:0] CMD_CODE    = 8'h01;
  localparam logic [7:0] CMD_LEN     = 8'd13;
  localparam logic [7:0] UPD_LEN     = 8'd14;
  localparam logic [15:0] UPD_DLEN   = 16'd4;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_IDLE_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_LINK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_LIGHT_OFF    = 2'd2;
  localparam logic [1:0] CFG_UPDATE_ADDR  = 2'd3;

  localparam logic [7:0]  IDLE_LIMIT_RST   = 8'd10;
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd1000;

  // Event codes of a result transaction.
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_APPLIED = 3'd1;
  localparam logic [2:0] EV_OTHER   = 3'd2;
  localparam logic [2:0] EV_UPDATE  = 3'd3;
  localparam logic [2:0] EV_REJECT  = 3'd4;
  localparam logic [2:0] EV_TIMEOUT = 3'd5;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [7:0]         light_command;
    logic [7:0]         control_bits;
    logic [7:0]         music_id;
    logic [7:0]         unit_kind;
    logic [7:0]         unit_action_id;
    logic [7:0]         unit_mode;
    logic signed [15:0] unit_parameter;
  } out_t;

endpackage

// ===== hw/rtl/serial_command_frame_receiver.sv =====
// Top level of the serial command frame receiver: frame parser, timers and result register.
//
// Usage: every input transaction is either a received serial byte or a tick that
// reports one poll of an empty receive queue. Each input transaction produces exactly
// one result transaction, in order. Bytes are assembled into command frames (header
// EE 51, then a length byte) or update frames (header 48 05, fourteen bytes in all);
// the XOR of all bytes of a frame must be zero. A completed frame is classified in
// the cycle its last byte arrives. Ticks advance an idle counter that drops a partial
// frame and a link counter that reports a timeout with the configured light-off code.
// The result is registered: the result of a transaction accepted at one edge is presented
// on out_valid after that edge. One transaction is taken per cycle unless in_stall is
// raised; the parser state and the result register update together at each accepted
// transaction. The result register serves as the output stage: while it holds a result
// that the receiver stalls, in_stall is raised and nothing new is accepted; when the
// receiver takes the result, a new transaction is accepted in the same cycle.
// Synchronous reset returns the parser to header hunting, clears the counters and
// the output valid, and loads the configuration registers with their defaults.
// Configuration writes take effect at the edge where cfg_wr_en is high.
module serial_command_frame_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scfr_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scfr_pkg::out_t      out_data,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wr_data
);
  import scfr_pkg::*;

  // Parser states.
  localparam logic [2:0] ST_HUNT     = 3'd0;
  localparam logic [2:0] ST_GOT_EE   = 3'd1;
  localparam logic [2:0] ST_GOT_51   = 3'd2;
  localparam logic [2:0] ST_BODY     = 3'd3;
  localparam logic [2:0] ST_GOT_48   = 3'd4;
  localparam logic [2:0] ST_UPD_BODY = 3'd5;

  // Configuration registers.
  logic [7:0]  idle_limit_r;
  logic [15:0] link_timeout_r;
  logic [7:0]  light_off_r;
  logic [31:0] update_addr_r;

  // Parser and timer state.
  logic [2:0]  state_r, state_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic [7:0]  idle_count_r, idle_count_nxt;
  logic [15:0] link_count_r, link_count_nxt;
  logic [7:0]  frame_buf_r [BUFFER_DEPTH];

  // Frame store write port.
  logic              buf_we;
  logic [BUF_AW-1:0] buf_wa;

  // Output stage.
  logic out_valid_r;
  out_t out_data_r, out_data_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  idle_inc;
  logic [15:0] link_inc;
  logic [7:0]  cnt_inc;
  logic [7:0]  limit;
  logic [7:0]  xor_new;
  logic [31:0] frame_addr;
  logic [15:0] frame_dlen;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b          = in_data.data_byte;
  assign idle_inc   = idle_count_r + 8'd1;
  assign link_inc   = link_count_r + 16'd1;
  assign cnt_inc    = byte_count_r + 8'd1;
  assign xor_new    = running_xor_r ^ b;
  assign limit      = (state_r == ST_BODY) ? frame_buf_r[2] : UPD_LEN;
  assign frame_addr = {frame_buf_r[5], frame_buf_r[4], frame_buf_r[3], frame_buf_r[2]};
  assign frame_dlen = {frame_buf_r[7], frame_buf_r[6]};

  // Next state and result for one transaction.
  always_comb begin
    state_nxt       = state_r;
    byte_count_nxt  = byte_count_r;
    running_xor_nxt = running_xor_r;
    idle_count_nxt  = idle_count_r;
    link_count_nxt  = link_count_r;
    buf_we          = 1'b0;
    buf_wa          = byte_count_r[BUF_AW-1:0];
    out_data_nxt    = '0;

    if (in_data.kind == KIND_TICK) begin
      idle_count_nxt = idle_inc;
      if (idle_inc >= idle_limit_r) begin
        idle_count_nxt = '0;
        state_nxt      = ST_HUNT;
        byte_count_nxt = '0;
      end
      link_count_nxt = link_inc;
      if (link_inc > link_timeout_r) begin
        link_count_nxt             = '0;
        out_data_nxt.event_res     = EV_TIMEOUT;
        out_data_nxt.light_command = light_off_r;
      end
    end else begin
      idle_count_nxt = '0;
      case (state_r)
        ST_HUNT: begin
          if (b == HDR_CMD_0 || b == HDR_UPD_0) begin
            state_nxt       = (b == HDR_CMD_0) ? ST_GOT_EE : ST_GOT_48;
            buf_we          = 1'b1;
            buf_wa          = BUF_AW'(0);
            byte_count_nxt  = 8'd1;
            running_xor_nxt = b;
          end
        end
        ST_GOT_EE, ST_GOT_48: begin
          if (b == ((state_r == ST_GOT_EE) ? HDR_CMD_1 : HDR_UPD_1)) begin
            state_nxt       = (state_r == ST_GOT_EE) ? ST_GOT_51 : ST_UPD_BODY;
            buf_we          = 1'b1;
            buf_wa          = BUF_AW'(1);
            byte_count_nxt  = 8'd2;
            running_xor_nxt = xor_new;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
        ST_GOT_51: begin
          buf_we          = 1'b1;
          buf_wa          = BUF_AW'(2);
          byte_count_nxt  = 8'd3;
          running_xor_nxt = xor_new;
          state_nxt       = ST_BODY;
        end
        ST_BODY, ST_UPD_BODY: begin
          // Bytes beyond the store are still counted and folded into the XOR.
          buf_we          = (32'(byte_count_r) < BUFFER_DEPTH);
          running_xor_nxt = xor_new;
          byte_count_nxt  = cnt_inc;
          if (cnt_inc >= limit || cnt_inc == 8'd0) begin
            state_nxt              = ST_HUNT;
            byte_count_nxt         = '0;
            out_data_nxt.event_res = EV_REJECT;
            if (cnt_inc == CMD_LEN) begin
              if (xor_new == 8'd0) begin
                // A good command-length frame restarts the link timer.
                link_count_nxt = '0;
                if (frame_buf_r[2] == CMD_LEN && frame_buf_r[3] == CMD_CODE) begin
                  out_data_nxt.event_res      = EV_APPLIED;
                  out_data_nxt.light_command  = frame_buf_r[4];
                  out_data_nxt.control_bits   = frame_buf_r[5];
                  out_data_nxt.music_id       = frame_buf_r[6];
                  out_data_nxt.unit_kind      = frame_buf_r[7];
                  out_data_nxt.unit_action_id = frame_buf_r[8];
                  out_data_nxt.unit_mode      = frame_buf_r[9];
                  out_data_nxt.unit_parameter = {frame_buf_r[11], frame_buf_r[10]};
                end else begin
                  out_data_nxt.event_res = EV_OTHER;
                end
              end
            end else if (cnt_inc == UPD_LEN) begin
              if (xor_new == 8'd0 && frame_buf_r[12] == UPD_TRAILER &&
                  frame_addr == update_addr_r && frame_dlen == UPD_DLEN &&
                  frame_buf_r[8] == UPD_FILL && frame_buf_r[9] == UPD_FILL &&
                  frame_buf_r[10] == UPD_FILL && frame_buf_r[11] == UPD_FILL) begin
                out_data_nxt.event_res = EV_UPDATE;
              end
            end
          end
        end
        default: begin
          state_nxt      = ST_HUNT;
          byte_count_nxt = '0;
        end
      endcase
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_HUNT;
      byte_count_r   <= '0;
      running_xor_r  <= '0;
      idle_count_r   <= '0;
      link_count_r   <= '0;
      out_valid_r    <= 1'b0;
      idle_limit_r   <= IDLE_LIMIT_RST;
      link_timeout_r <= LINK_TIMEOUT_RST;
      light_off_r    <= '0;
      update_addr_r  <= '0;
    end else begin
      if (accept) begin
        state_r       <= state_nxt;
        byte_count_r  <= byte_count_nxt;
        running_xor_r <= running_xor_nxt;
        idle_count_r  <= idle_count_nxt;
        link_count_r  <= link_count_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDLE_LIMIT:   idle_limit_r   <= cfg_wr_data[7:0];
          CFG_LINK_TIMEOUT: link_timeout_r <= cfg_wr_data[15:0];
          CFG_LIGHT_OFF:    light_off_r    <= cfg_wr_data[7:0];
          CFG_UPDATE_ADDR:  update_addr_r  <= cfg_wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: frame store and result.
  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      frame_buf_r[buf_wa] <= b;
    end
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== dv/tb_serial_command_frame_receiver.sv =====
// Self-checking testbench for the serial command frame receiver, with its scoreboard.
`timescale 1ns / 100ps

module tb_serial_command_frame_receiver;
  import scfr_pkg::*;

  // Number of cycles the receiver holds off once, so that the result stage fills up.
  localparam int unsigned HOLD_CYCLES = 48;
  // The run is declared hung after this many cycles in which no transaction completes.
  localparam int unsigned STUCK_LIMIT = 2000;

  // Parser position of the frame hunter, mirrored in the scoreboard.
  typedef enum logic [2:0] {
    P_HUNT, P_GOT_EE, P_GOT_51, P_BODY, P_GOT_48, P_UPD_BODY
  } parse_e;

  // How a generated frame is spoiled before it goes out.
  typedef enum logic [1:0] {INTACT, FIELD_HIT, SUM_HIT} damage_e;

  // The scoreboard keeps its own copy of the parser, the timers and the registers. Every
  // accepted input transaction is run through that copy, and the result it must produce
  // is queued until the matching result transaction shows up on the output.
  class frame_scoreboard;
    logic [7:0]  max_idle_polls;
    logic [15:0] link_limit;
    logic [7:0]  off_light;
    logic [31:0] flash_addr;
    parse_e      step;
    logic [7:0]  count;
    logic [7:0]  frame_mem [BUFFER_DEPTH];
    logic [7:0]  chk;
    logic [7:0]  idle_polls;
    logic [15:0] link_ticks;
    out_t        expected_results [$];
    int unsigned inputs_seen;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned event_tally [6];

    function new();
      max_idle_polls = IDLE_LIMIT_RST;
      link_limit     = LINK_TIMEOUT_RST;
      off_light      = 8'h00;
      flash_addr     = 32'h0;
      step           = P_HUNT;
      count          = 8'h00;
      chk            = 8'h00;
      idle_polls     = 8'h00;
      link_ticks     = 16'h0;
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      foreach (event_tally[i]) event_tally[i] = 0;
      inputs_seen  = 0;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_IDLE_LIMIT:   max_idle_polls = val[7:0];
        CFG_LINK_TIMEOUT: link_limit     = val[15:0];
        CFG_LIGHT_OFF:    off_light      = val[7:0];
        CFG_UPDATE_ADDR:  flash_addr     = val;
        default: ;
      endcase
    endfunction

    function int unsigned waiting();
      return expected_results.size();
    endfunction

    function string show(out_t v);
      return $sformatf({"event %0d light %02h ctrl %02h music %02h kind %02h id %02h",
                        " mode %02h param %0d"},
                       v.event_res, v.light_command, v.control_bits, v.music_id, v.unit_kind,
                       v.unit_action_id, v.unit_mode, v.unit_parameter);
    endfunction

    function void note_input(in_t item);
      out_t       r;
      logic [7:0] b;
      logic [7:0] body_len;
      logic [7:0] frame_len;
      r = '0;
      b = item.data_byte;
      inputs_seen++;
      if (item.kind == KIND_TICK) begin
        idle_polls = idle_polls + 8'd1;
        if (idle_polls >= max_idle_polls) begin
          idle_polls = 8'h00;
          step       = P_HUNT;
          count      = 8'h00;
        end
        link_ticks = link_ticks + 16'd1;
        if (link_ticks > link_limit) begin
          link_ticks      = 16'h0;
          r.event_res     = EV_TIMEOUT;
          r.light_command = off_light;
        end
      end else begin
        idle_polls = 8'h00;
        case (step)
          P_HUNT: begin
            if (b == HDR_CMD_0 || b == HDR_UPD_0) begin
              step         = (b == HDR_CMD_0) ? P_GOT_EE : P_GOT_48;
              frame_mem[0] = b;
              count        = 8'd1;
              chk          = b;
            end
          end
          P_GOT_EE, P_GOT_48: begin
            // A wrong second byte drops the header and is not looked at again.
            if (b == ((step == P_GOT_EE) ? HDR_CMD_1 : HDR_UPD_1)) begin
              step         = (step == P_GOT_EE) ? P_GOT_51 : P_UPD_BODY;
              frame_mem[1] = b;
              count        = 8'd2;
              chk          = chk ^ b;
            end else begin
              step = P_HUNT;
            end
          end
          P_GOT_51: begin
            frame_mem[2] = b;
            count        = 8'd3;
            chk          = chk ^ b;
            step         = P_BODY;
          end
          default: begin
            body_len = (step == P_BODY) ? frame_mem[2] : UPD_LEN;
            if (count < BUFFER_DEPTH) frame_mem[count[BUF_AW-1:0]] = b;
            chk   = chk ^ b;
            count = count + 8'd1;
            if (count >= body_len || count == 8'h00) begin
              frame_len   = count;
              step        = P_HUNT;
              count       = 8'h00;
              r.event_res = EV_REJECT;
              if (frame_len == CMD_LEN) begin
                if (chk == 8'h00) begin
                  link_ticks = 16'h0;
                  if (frame_mem[2] == CMD_LEN && frame_mem[3] == CMD_CODE) begin
                    r.event_res      = EV_APPLIED;
                    r.light_command  = frame_mem[4];
                    r.control_bits   = frame_mem[5];
                    r.music_id       = frame_mem[6];
                    r.unit_kind      = frame_mem[7];
                    r.unit_action_id = frame_mem[8];
                    r.unit_mode      = frame_mem[9];
                    r.unit_parameter = {frame_mem[11], frame_mem[10]};
                  end else begin
                    r.event_res = EV_OTHER;
                  end
                end
              end else if (frame_len == UPD_LEN) begin
                // The checksum, trailer, address, data length and fill are checked here.
                if (chk == 8'h00 && frame_mem[12] == UPD_TRAILER &&
                    {frame_mem[5], frame_mem[4], frame_mem[3], frame_mem[2]} == flash_addr &&
                    {frame_mem[7], frame_mem[6]} == UPD_DLEN &&
                    frame_mem[8] == UPD_FILL && frame_mem[9] == UPD_FILL &&
                    frame_mem[10] == UPD_FILL && frame_mem[11] == UPD_FILL)
                  r.event_res = EV_UPDATE;
              end
            end
          end
        endcase
      end
      event_tally[r.event_res]++;
      expected_results.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR at %0t: result with no transaction waiting: %s", $time, show(got));
        return;
      end
      want = expected_results.pop_front();
      if (got.event_res !== want.event_res || got.light_command !== want.light_command ||
          got.control_bits !== want.control_bits || got.music_id !== want.music_id ||
          got.unit_kind !== want.unit_kind || got.unit_action_id !== want.unit_action_id ||
          got.unit_mode !== want.unit_mode || got.unit_parameter !== want.unit_parameter) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR at %0t: result %0d differs", $time, results_seen);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wr_data;

  frame_scoreboard sb;
  logic [7:0]      frame_bytes [$];
  bit              idling_on = 1'b0;
  bit              hold_req = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     stall_left = 0;
  int unsigned     stuck_cycles = 0;

  serial_command_frame_receiver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Both channels are sampled at the rising edge, before the block's own updates of that
  // edge land, so the values seen here are the ones the block acted on. A result is
  // checked before the input of the same edge is noted; the result always belongs to an
  // earlier transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // Result side. A hold request from the stimulus blocks results for a long stretch;
  // otherwise, while idling is enabled, the receiver stalls in short random bursts.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hang detection: any cycle that completes a transaction on either channel restarts it.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("Run hung: no transaction for %0d cycles", STUCK_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one input transaction and returns at the edge where it is taken. Valid may first
  // be held low at random; once raised, it is never lowered until the transaction
  // completes.
  task automatic send_item(input logic k, input logic [7:0] b);
    in_t item;
    item.kind      = k;
    item.data_byte = b;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Ticks carry a random byte that the block must ignore.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(KIND_TICK, 8'($urandom));
  endtask

  // Stops offering and waits until every expected result has been checked. The queue is
  // read at the falling edge so that the monitor of the last rising edge has run.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.waiting() != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Command frame with its length byte 13 and the given command code; the payload bytes
  // four to eleven are random.
  function automatic void build_command(input logic [7:0] code);
    frame_bytes = {HDR_CMD_0, HDR_CMD_1, CMD_LEN, code};
    repeat (8) frame_bytes.push_back(8'($urandom));
  endfunction

  // Update request frame. Under the command header the length byte sits where the low
  // address byte belongs, so such a frame only matches when that address byte is 14.
  function automatic void build_update(input logic [7:0] hdr);
    frame_bytes = {hdr, (hdr == HDR_CMD_0) ? HDR_CMD_1 : HDR_UPD_1,
                   (hdr == HDR_CMD_0) ? UPD_LEN : sb.flash_addr[7:0],
                   sb.flash_addr[15:8], sb.flash_addr[23:16], sb.flash_addr[31:24],
                   UPD_DLEN[7:0], UPD_DLEN[15:8],
                   UPD_FILL, UPD_FILL, UPD_FILL, UPD_FILL, UPD_TRAILER};
  endfunction

  // Command-header frame of any announced length; a length below four still ends after
  // the fourth byte.
  function automatic void build_length(input logic [7:0] len);
    int unsigned body;
    body = (len < 8'd4) ? 0 : int'(len) - 4;
    frame_bytes = {HDR_CMD_0, HDR_CMD_1, len};
    repeat (body) frame_bytes.push_back(8'($urandom));
  endfunction

  // Closes the frame with its checksum byte and sends it, now and then with ticks in
  // between bytes. A field hit changes one byte after the header and keeps the checksum
  // consistent; a sum hit spoils the checksum only.
  task automatic send_frame(input damage_e dmg);
    logic [7:0]  sum;
    int unsigned pos;
    if (dmg == FIELD_HIT) begin
      pos = $urandom_range(2, frame_bytes.size() - 1);
      frame_bytes[pos] = 8'($urandom);
    end
    sum = 8'h00;
    foreach (frame_bytes[i]) sum = sum ^ frame_bytes[i];
    if (dmg == SUM_HIT) sum = sum ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    foreach (frame_bytes[i]) begin
      if ($urandom_range(0, 19) == 0) send_ticks($urandom_range(1, 3));
      send_item(KIND_BYTE, frame_bytes[i]);
    end
  endtask

  // One random slice of traffic: mostly well-formed frames, some spoiled ones, frames of
  // odd and oversized lengths, runs of ticks and loose noise bytes.
  task automatic send_random_chunk();
    int unsigned pick;
    int unsigned spoil;
    damage_e     dmg;
    pick  = $urandom_range(0, 99);
    spoil = $urandom_range(0, 9);
    dmg   = (spoil == 0) ? SUM_HIT : (spoil <= 2) ? FIELD_HIT : INTACT;
    if (pick < 30) begin
      build_command(CMD_CODE);
      send_frame(dmg);
    end else if (pick < 45) begin
      build_update(HDR_UPD_0);
      send_frame(dmg);
    end else if (pick < 50) begin
      build_update(HDR_CMD_0);
      send_frame(dmg);
    end else if (pick < 58) begin
      build_command(8'($urandom));
      send_frame(dmg);
    end else if (pick < 68) begin
      build_length(8'($urandom_range(0, 16)));
      send_frame(dmg);
    end else if (pick < 76) begin
      // Longer than the frame store: the tail is counted but not kept. Most stay short
      // to save time; a few run up to the largest length.
      build_length(($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 255))
                                               : 8'($urandom_range(17, 32)));
      send_frame(dmg);
    end else if (pick < 90) begin
      send_ticks($urandom_range(1, 24));
    end else begin
      repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, 8'($urandom));
    end
  endtask

  // One test phase: wait for the block to go idle, load all four registers, then send
  // random traffic. Optionally the receiver holds off once, or the sender pauses once
  // halfway until all results are in.
  task automatic run_phase(input logic [7:0] idle_lim, input logic [15:0] link_lim,
                           input logic [7:0] light, input logic [31:0] addr,
                           input int unsigned n_items, input bit quiet,
                           input bit with_hold, input bit with_pause);
    int unsigned stop_at;
    int unsigned half_at;
    bit          mid_done;
    drain_results();
    cfg_write(CFG_IDLE_LIMIT, {24'h0, idle_lim});
    cfg_write(CFG_LINK_TIMEOUT, {16'h0, link_lim});
    cfg_write(CFG_LIGHT_OFF, {24'h0, light});
    cfg_write(CFG_UPDATE_ADDR, addr);
    cfg_wr_en <= 1'b0;
    stop_at  = sb.inputs_seen + n_items;
    half_at  = sb.inputs_seen + n_items / 2;
    mid_done = 1'b0;
    while (sb.inputs_seen < stop_at) begin
      // Idling comes and goes per slice, leaving stretches with none at all.
      idling_on = !quiet && ($urandom_range(0, 3) != 0);
      if (!mid_done && sb.inputs_seen >= half_at) begin
        mid_done = 1'b1;
        if (with_hold) hold_req = 1'b1;
        if (with_pause) drain_results();
      end
      send_random_chunk();
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_IDLE_LIMIT;
    cfg_wr_data = 32'h0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset settings.
    idling_on = 1'b1;
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_TICK, 8'hFF);
    // A second EE where 51 should follow drops the header and is not taken as a new
    // header, so the 51 after it is plain noise.
    send_item(KIND_BYTE, HDR_CMD_0);
    send_item(KIND_BYTE, HDR_CMD_0);
    send_item(KIND_BYTE, HDR_CMD_1);
    // A length byte of zero still ends the frame after its fourth byte.
    build_length(8'h00);
    send_frame(INTACT);
    // A valid command carrying the most negative parameter.
    frame_bytes = {HDR_CMD_0, HDR_CMD_1, CMD_LEN, CMD_CODE, 8'hFF, 8'h00, 8'hFF, 8'h00,
                   8'h80, 8'h7F, 8'h00, 8'h80};
    send_frame(INTACT);

    // Largest limits: nothing times out and partial frames live long.
    run_phase(8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 300, 1'b0, 1'b1, 1'b0);
    // Smallest limits: every tick drops a partial frame and reports a link timeout.
    run_phase(8'h01, 16'h0000, 8'h00, 32'h0000_0000, 250, 1'b0, 1'b0, 1'b0);
    // The low address byte equals the update length, so command-header updates can match.
    run_phase(8'h03, 16'd20, 8'hA5, {8'($urandom), 8'($urandom), 8'($urandom), UPD_LEN},
              350, 1'b0, 1'b0, 1'b1);
    run_phase(8'($urandom_range(1, 12)), 16'($urandom_range(0, 300)), 8'($urandom), $urandom,
              350, 1'b0, 1'b0, 1'b0);
    run_phase(IDLE_LIMIT_RST, LINK_TIMEOUT_RST, 8'($urandom), $urandom, 300, 1'b0, 1'b0, 1'b0);
    // Closing stretch at full rate with no idling on either side.
    run_phase(8'h08, 16'd50, 8'h5A, $urandom, 250, 1'b1, 1'b0, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);

    $display("Run covered %0d input transactions and %0d results at the reset settings %s",
             sb.inputs_seen, sb.results_seen, "and six register loads.");
    $display("Events: %0d applied, %0d other, %0d update, %0d rejected, %0d timeout, %0d none.",
             sb.event_tally[EV_APPLIED], sb.event_tally[EV_OTHER], sb.event_tally[EV_UPDATE],
             sb.event_tally[EV_REJECT], sb.event_tally[EV_TIMEOUT], sb.event_tally[EV_NONE]);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d", sb.mismatches, sb.waiting());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
